>>> sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication into the next cycle, off while reset is high
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// implication into the next cycle, checked through reset as well
`define ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/wpes_pkg.sv
package wpes_pkg;

   localparam int STORE_DEPTH  = 16;
   localparam int SCORE_BITS   = 32;
   localparam int TIME_BITS    = 32;
   localparam int NUMBER_BITS  = 32;
   localparam int HW_BITS      = 16;
   localparam int COUNT_BITS   = $clog2(STORE_DEPTH + 1);
   localparam int IDX_BITS     = $clog2(STORE_DEPTH);
   localparam logic [HW_BITS-1:0] HW_RESET = HW_BITS'(50);

   typedef logic signed [SCORE_BITS-1:0] score_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]   time_stamp;
      score_type              score;
      logic [NUMBER_BITS-1:0] number;
      logic                   cand;
   } entry_type;

   typedef struct packed {
      logic [NUMBER_BITS-1:0] number;
      logic                   keep;
      logic                   overflow;
   } result_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

>>> sv/windowed_peak_event_selector.sv
// each request scans the stored events at the head cell, inserts the new event,
// then finishes; on a list end it first flushes every stored event out
// the head cell examines one stored event per cycle, unless the result buffer stalls
// a new request is accepted only once the previous one has finished
// reset: synchronous, empties the store, zeroes the event counter, half_width 50
module windowed_peak_event_selector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [wpes_pkg::TIME_BITS-1:0] req_event_time,
   input  logic signed [31:0]            req_event_score,
   input  logic                          req_last_event,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_event_index,
   output logic                          rsp_keep,
   output logic                          rsp_overflow,
   output logic                          rsp_last_result,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wpes_pkg::HW_BITS-1:0]  csr_half_width
);
   import wpes_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  len_ff, len_in;
   logic [COUNT_BITS-1:0]  scan_ff, scan_in;
   logic [TIME_BITS-1:0]   t_ff, t_in;
   score_type              score_ff, score_in;
   logic                   last_ff, last_in;
   logic                   cand_ff, cand_in;
   logic [NUMBER_BITS-1:0] next_number_ff, next_number_in;
   logic [HW_BITS-1:0]     hw_ff, hw_in;

   entry_type              cell_entry [STORE_DEPTH];
   cell_ctrl_type          cell_ctrl [STORE_DEPTH];
   entry_type              head;
   entry_type              new_entry;
   entry_type              load_data;
   logic                   load_en;
   logic                   shift_en;
   logic [IDX_BITS-1:0]    load_pos;
   logic [COUNT_BITS-1:0]  len_minus_one;
   logic                   closed;
   score_type              req_score;

   logic                   push;
   result_type             push_data;
   logic                   finish;
   logic                   buf_ready;

   assign head          = cell_entry[0];
   assign new_entry     = '{time_stamp: t_ff, score: score_ff, number: next_number_ff,
                            cand: cand_ff};
   assign len_minus_one = len_ff - COUNT_BITS'(1);
   assign req_score     = $signed(req_event_score[SCORE_BITS-1:0]);
   assign closed        = {1'b0, t_ff} > ({1'b0, head.time_stamp} + (TIME_BITS + 1)'(hw_ff));

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      scan_in        = scan_ff;
      t_in           = t_ff;
      score_in       = score_ff;
      last_in        = last_ff;
      cand_in        = cand_ff;
      next_number_in = next_number_ff;
      hw_in          = hw_ff;
      shift_en       = 1'b0;
      load_en        = 1'b0;
      load_pos       = len_ff[IDX_BITS-1:0];
      load_data      = new_entry;
      push           = 1'b0;
      push_data      = '{number: head.number, keep: head.cand, overflow: 1'b0};
      finish         = 1'b0;

      if (csr_valid && csr_ready) begin
         hw_in = csr_half_width;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               t_in     = req_event_time;
               score_in = req_score;
               last_in  = req_last_event;
               cand_in  = req_score > score_type'(0);
               scan_in  = len_ff;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == '0) begin
               state_in = ST_INSERT;
            end else if (closed) begin
               // right window over: decide and drop the head
               if (buf_ready) begin
                  push     = 1'b1;
                  shift_en = 1'b1;
                  len_in   = len_minus_one;
                  scan_in  = scan_ff - COUNT_BITS'(1);
               end
            end else begin
               // still open: compare both ways and send the head round to the tail
               shift_en       = 1'b1;
               load_en        = 1'b1;
               load_pos       = len_minus_one[IDX_BITS-1:0];
               load_data      = head;
               load_data.cand = head.cand && !($signed(score_ff) > $signed(head.score));
               cand_in        = cand_ff && !($signed(head.score) >= $signed(score_ff));
               scan_in        = scan_ff - COUNT_BITS'(1);
            end
         end
         ST_INSERT: begin
            if (len_ff == COUNT_BITS'(STORE_DEPTH)) begin
               // store full: oldest goes out early, new event lands in the last cell
               if (buf_ready) begin
                  push               = 1'b1;
                  push_data.overflow = 1'b1;
                  shift_en           = 1'b1;
                  load_en            = 1'b1;
                  load_pos           = IDX_BITS'(STORE_DEPTH - 1);
                  next_number_in     = next_number_ff + NUMBER_BITS'(1);
                  state_in           = last_ff ? ST_FLUSH : ST_FINISH;
               end
            end else begin
               load_en        = 1'b1;
               len_in         = len_ff + COUNT_BITS'(1);
               next_number_in = next_number_ff + NUMBER_BITS'(1);
               state_in       = last_ff ? ST_FLUSH : ST_FINISH;
            end
         end
         ST_FLUSH: begin
            if (len_ff == '0) begin
               next_number_in = '0;
               state_in       = ST_FINISH;
            end else if (buf_ready) begin
               push     = 1'b1;
               shift_en = 1'b1;
               len_in   = len_minus_one;
            end
         end
         ST_FINISH: begin
            if (buf_ready) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         len_ff         <= '0;
         scan_ff        <= '0;
         next_number_ff <= '0;
         hw_ff          <= HW_RESET;
      end else begin
         state_ff       <= state_in;
         len_ff         <= len_in;
         scan_ff        <= scan_in;
         next_number_ff <= next_number_in;
         hw_ff          <= hw_in;
      end
      t_ff     <= t_in;
      score_ff <= score_in;
      last_ff  <= last_in;
      cand_ff  <= cand_in;
   end

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      entry_type right_entry;

      assign cell_ctrl[i].shift = shift_en;
      assign cell_ctrl[i].load  = load_en && (load_pos == IDX_BITS'(i));

      if (i == STORE_DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cell_entry[i + 1];
      end

      wpes_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .right_in  (right_entry),
         .load_in   (load_data),
         .entry_out (cell_entry[i])
      );
   end

   wpes_rsp_buf u_rsp_buf (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .push_data       (push_data),
      .finish          (finish),
      .ready           (buf_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_index (rsp_event_index),
      .rsp_keep        (rsp_keep),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_result (rsp_last_result)
   );

endmodule

>>> sv/wpes_cell.sv
module wpes_cell (
   input  logic                    clock,
   input  wpes_pkg::cell_ctrl_type ctrl,
   input  wpes_pkg::entry_type     right_in,
   input  wpes_pkg::entry_type     load_in,
   output wpes_pkg::entry_type     entry_out
);
   import wpes_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // shift toward the head, a cell selected for load takes the load bus instead
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = right_in;
      end
      if (ctrl.load) begin
         entry_in = load_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

>>> sv/wpes_rsp_buf.sv
module wpes_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wpes_pkg::result_type   push_data,
   input  logic                   finish,
   output logic                   ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_event_index,
   output logic                   rsp_keep,
   output logic                   rsp_overflow,
   output logic                   rsp_last_result
);
   import wpes_pkg::*;

   logic       hold_valid_ff, hold_valid_in;
   result_type hold_ff, hold_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       out_last_ff, out_last_in;
   logic       out_free;

   assign out_free = !out_valid_ff || rsp_ready;
   assign ready    = !hold_valid_ff || out_free;

   // one result is held back until it is known whether it closes the request
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      if (push && ready) begin
         if (hold_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = hold_ff;
            out_last_in  = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_in       = push_data;
      end
      if (finish && ready) begin
         if (hold_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = hold_ff;
            out_last_in  = 1'b1;
         end
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_index = out_ff.number;
   assign rsp_keep        = out_ff.keep;
   assign rsp_overflow    = out_ff.overflow;
   assign rsp_last_result = out_last_ff;

endmodule

>>> sv/wpes_checker.sv
`include "assert_macros.svh"

module wpes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_event_index,
   input logic        rsp_keep,
   input logic        rsp_overflow,
   input logic        rsp_last_result
);

   logic        rsp_stall;
   logic [34:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_event_index, rsp_keep, rsp_overflow, rsp_last_result};

   // a stalled result keeps its fields
   `ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   // one request in work at a time
   `ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready, "request taken while busy")

   // nothing comes out right after reset
   `ASSERT_NEXT_ALWAYS(a_reset_quiet, reset, !rsp_valid, "result valid after reset")

endmodule

bind windowed_peak_event_selector wpes_checker u_wpes_checker (.*);

>>> tb/windowed_peak_event_selector_tb.sv
module windowed_peak_event_selector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_EVENTS   = 17;

   typedef struct packed {
      wpes_pkg::result_type res;
      logic                 last;
   } decision_type;

   class peak_decision_board;
      logic [wpes_pkg::HW_BITS-1:0] half_width;
      wpes_pkg::entry_type          window_store[$];
      logic [31:0]                  next_number;
      decision_type                 pending_decisions[$];
      int errors;
      int events_noted;
      int lists_ended;
      int decisions_checked;
      int kept_seen;
      int overflow_seen;

      function new();
         half_width = wpes_pkg::HW_RESET;
         next_number = '0;
         errors = 0;
         events_noted = 0;
         lists_ended = 0;
         decisions_checked = 0;
         kept_seen = 0;
         overflow_seen = 0;
      endfunction

      function void set_half_width(logic [wpes_pkg::HW_BITS-1:0] value);
         half_width = value;
      endfunction

      function int outstanding();
         return pending_decisions.size();
      endfunction

      function void push_decision(logic [31:0] number, logic keep, logic early);
         decision_type d;
         d.res.number = number;
         d.res.keep = keep;
         d.res.overflow = early;
         d.last = 1'b0;
         pending_decisions.push_back(d);
      endfunction

      // works out every decision that one accepted request releases
      function void note_event(logic [31:0] stamp, wpes_pkg::score_type score,
                               logic list_end);
         int i;
         int first_new;
         logic cand;
         wpes_pkg::entry_type e;
         decision_type d;
         first_new = pending_decisions.size();
         cand = (score > 0);
         events_noted++;
         i = 0;
         while (i < window_store.size()) begin
            // window edge is computed at 33 bits, no wrap
            if ({1'b0, stamp} > {1'b0, window_store[i].time_stamp} + {17'b0, half_width}) begin
               push_decision(window_store[i].number, window_store[i].cand, 1'b0);
               window_store.delete(i);
            end else begin
               i++;
            end
         end
         for (int j = 0; j < window_store.size(); j++) begin
            e = window_store[j];
            if ($signed(e.score) >= score)
               cand = 1'b0;
            if (score > $signed(e.score)) begin
               e.cand = 1'b0;
               window_store[j] = e;
            end
         end
         if (window_store.size() >= wpes_pkg::STORE_DEPTH) begin
            push_decision(window_store[0].number, window_store[0].cand, 1'b1);
            void'(window_store.pop_front());
         end
         e.time_stamp = stamp;
         e.score = score;
         e.number = next_number;
         e.cand = cand;
         window_store.push_back(e);
         next_number++;
         if (list_end) begin
            foreach (window_store[k])
               push_decision(window_store[k].number, window_store[k].cand, 1'b0);
            window_store.delete();
            next_number = '0;
            lists_ended++;
         end
         if (pending_decisions.size() > first_new) begin
            d = pending_decisions.pop_back();
            d.last = 1'b1;
            pending_decisions.push_back(d);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_decision(logic [31:0] index, logic keep, logic early,
                                   logic last_flag);
         decision_type want;
         if (pending_decisions.size() == 0) begin
            $display("%0t: unexpected result, expected none, got index %0d keep %0b",
                     $time, index, keep);
            errors++;
            return;
         end
         want = pending_decisions.pop_front();
         decisions_checked++;
         if (keep === 1'b1)
            kept_seen++;
         if (early === 1'b1)
            overflow_seen++;
         compare_field("event_index", want.res.number, index);
         compare_field("keep", 32'(want.res.keep), 32'(keep));
         compare_field("overflow", 32'(want.res.overflow), 32'(early));
         compare_field("last_result", 32'(want.last), 32'(last_flag));
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [wpes_pkg::TIME_BITS-1:0]   req_event_time = '0;
   logic signed [31:0]               req_event_score = '0;
   logic                             req_last_event = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [31:0]                      rsp_event_index;
   logic                             rsp_keep;
   logic                             rsp_overflow;
   logic                             rsp_last_result;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [wpes_pkg::HW_BITS-1:0]     csr_half_width = '0;

   peak_decision_board               sb;
   bit                               hold_decisions = 1'b0;
   int                               quiet_cycles = 0;
   int                               request_run = 0;
   logic [wpes_pkg::HW_BITS-1:0]     hw_plan [5];

   windowed_peak_event_selector u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_event_time  (req_event_time),
      .req_event_score (req_event_score),
      .req_last_event  (req_last_event),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_index (rsp_event_index),
      .rsp_keep        (rsp_keep),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_result (rsp_last_result),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_half_width  (csr_half_width)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // bursts of back-to-back transfers mixed with random gaps
   function automatic int draw_gap(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         run_left = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   function automatic wpes_pkg::score_type draw_score();
      int v;
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3, 4: return $urandom();
         default: begin
            // few distinct values so that ties show up often
            v = int'($urandom_range(0, 8)) - 4;
            return v * 65536 + int'($urandom_range(0, 1));
         end
      endcase
   endfunction

   function automatic logic [31:0] next_stamp(logic [31:0] prev, logic [15:0] hw);
      int unsigned back;
      int unsigned step;
      logic [32:0] sum;
      if ($urandom_range(0, 11) == 0) begin
         // out of order within a list
         back = $urandom_range(0, hw + 2);
         return (back > prev) ? 32'd0 : prev - back;
      end
      case ($urandom_range(0, 7))
         0: step = 0;
         1: step = 32'(hw);
         2: step = 32'(hw) + 32'd1;
         6: step = $urandom_range(0, 2 * hw + 2);
         7: step = $urandom_range(0, 1 << 20);
         default: step = $urandom_range(0, hw / 2 + 1);
      endcase
      sum = {1'b0, prev} + step;
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   task automatic send_request(input logic [31:0] stamp, input wpes_pkg::score_type score,
                               input logic list_end);
      int gap;
      gap = draw_gap(request_run);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_event_time <= stamp;
      req_event_score <= score;
      req_last_event <= list_end;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      sb.note_event(stamp, score, list_end);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      // a request that releases nothing may still be in progress
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_half_width(input logic [wpes_pkg::HW_BITS-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_half_width <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_half_width(value);
   endtask

   task automatic run_random_phase(input int count, input bit pause_mid, input bit stall_mid);
      int sent;
      int list_left;
      logic [31:0] stamp;
      sent = 0;
      list_left = 0;
      stamp = '0;
      while (sent < count) begin
         if (list_left == 0) begin
            list_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
               0: stamp = $urandom_range(0, 100);
               1: stamp = 32'hFFFF_FFFF - 32'($urandom_range(0, 2 * sb.half_width + 40));
               default: stamp = $urandom();
            endcase
         end else begin
            stamp = next_stamp(stamp, sb.half_width);
         end
         list_left--;
         send_request(stamp, draw_score(), list_left == 0);
         sent++;
         if (stall_mid && sent == count / 3)
            hold_decisions = 1'b1;
         if (pause_mid && sent == count / 2)
            drain_results();
      end
   endtask

   initial begin : result_sink
      int gap;
      int run_left;
      run_left = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = draw_gap(run_left);
         if (hold_decisions) begin
            hold_decisions = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         sb.check_decision(rsp_event_index, rsp_keep, rsp_overflow, rsp_last_result);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
          || (csr_valid && csr_ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, sb.outstanding());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      sb = new();
      hw_plan = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 65534)), 16'd3, 16'd200};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed list at the reset window of 50
      send_request(32'd0, 32'sh7FFF_FFFF, 1'b0);
      send_request(32'd10, 32'sh8000_0000, 1'b0);
      send_request(32'd20, 32'sd0, 1'b0);
      // equal score later in the window: the earlier one wins
      send_request(32'd20, 32'sh7FFF_FFFF, 1'b0);
      send_request(32'd200, 32'sd327680, 1'b0);
      // earlier time than the last event
      send_request(32'd100, 32'sd393216, 1'b0);
      // seventeen events inside one window overrun the store
      for (int i = 0; i < 17; i++)
         send_request(32'd1000 + 32'(i), 32'((i % 5) * 65536 - 65536), 1'b0);
      send_request(32'hFFFF_FFF0, 32'sd1, 1'b0);
      // window end past the top of the time range
      send_request(32'hFFFF_FFFF, 32'sd2, 1'b1);

      foreach (hw_plan[p]) begin
         write_half_width(hw_plan[p]);
         run_random_phase(PHASE_EVENTS, p == 3, p == 1);
      end

      drain_results();
      $display("covered %0d events in %0d closed lists, %0d results checked",
               sb.events_noted, sb.lists_ended, sb.decisions_checked);
      $display("%0d kept, %0d forced out of a full store, windows %0d %0d %0d %0d %0d",
               sb.kept_seen, sb.overflow_seen, hw_plan[0], hw_plan[1], hw_plan[2],
               hw_plan[3], hw_plan[4]);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
